FILE: hw/rtl/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = 7;
  localparam int POS_W      = 7;
  localparam int OP_W       = 3;
  localparam int ST_W       = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef logic [DATA_WIDTH-1:0] elem_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT_UP,
    S_INS_WRITE,
    S_SHIFT_DN
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    elem_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

FILE: hw/rtl/ple_store.sv
module ple_store (
  input  logic              clk,
  input  ple_pkg::mem_req_t req,
  output ple_pkg::elem_t    rdata
);

  ple_pkg::elem_t mem [ple_pkg::CAPACITY];
  ple_pkg::elem_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/positional_list_engine_core.sv
// Ordered list of up to 64 signed 32-bit words held in a single-port-per-side RAM.
// A request is taken when start is high and busy is low; exactly one result word
// follows, shown for one cycle with out_valid high, and the receiver cannot stall it.
// Append, clear, unknown opcodes, rejected requests, insert at the end of the list and
// remove of the last word finish in the accept cycle and their result appears on the
// next cycle. Read issues the RAM read in the accept cycle and finishes in S_RD_WAIT.
// An insert at a position p below the list length n and a remove below n - 1 move the
// elements behind p one RAM read and one RAM write per cycle, in S_SHIFT_UP (followed
// by S_INS_WRITE for the new word) or S_SHIFT_DN; the longest request is an insert at
// the front of a list of 63 words. busy is high while a request is in progress.
module positional_list_engine_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ple_pkg::OP_W-1:0]    in_opcode,
  input  logic [ple_pkg::POS_W-1:0]   in_position,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  output logic signed [31:0]          out_read_value,
  output logic [ple_pkg::CNT_W-1:0]   out_count,
  output logic                        out_is_empty,
  output logic [ple_pkg::ST_W-1:0]    out_status
);

  ple_pkg::state_t            state_r, state_nxt;
  logic [ple_pkg::CNT_W-1:0]  count_r, count_nxt;
  ple_pkg::addr_t             idx_r, idx_nxt;
  ple_pkg::addr_t             pos_r, pos_nxt;
  ple_pkg::elem_t             val_r, val_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [31:0]         out_read_value_r, out_read_value_nxt;
  logic [ple_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;
  logic                       out_is_empty_r, out_is_empty_nxt;
  ple_pkg::status_t           out_status_r, out_status_nxt;

  ple_pkg::mem_req_t          mem_req;
  ple_pkg::elem_t             mem_rdata;

  logic                       done;
  ple_pkg::status_t           st;
  ple_pkg::elem_t             rd;
  ple_pkg::addr_t             in_addr;
  ple_pkg::addr_t             cnt_addr;

  ple_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign in_addr  = in_position[ple_pkg::ADDR_W-1:0];
  assign cnt_addr = count_r[ple_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r            <= idx_nxt;
    pos_r            <= pos_nxt;
    val_r            <= val_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_count_r      <= out_count_nxt;
    out_is_empty_r   <= out_is_empty_nxt;
    out_status_r     <= out_status_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    mem_req       = '0;
    done          = 1'b0;
    st            = ple_pkg::ST_OK;
    rd            = '0;

    case (state_r)
      ple_pkg::S_IDLE: begin
        if (start) begin
          pos_nxt = in_addr;
          val_nxt = in_value;
          case (in_opcode)
            ple_pkg::OP_APPEND: begin
              done = 1'b1;
              if (count_r == ple_pkg::CAP_CNT) begin
                st = ple_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_addr;
                mem_req.wdata = in_value;
                count_nxt     = count_r + 1'b1;
              end
            end
            ple_pkg::OP_INSERT: begin
              if (in_position > count_r) begin
                done = 1'b1;
                st   = ple_pkg::ST_RANGE;
              end else if (count_r == ple_pkg::CAP_CNT) begin
                done = 1'b1;
                st   = ple_pkg::ST_FULL;
              end else if (in_position == count_r) begin
                // Insert at the end needs no move.
                done          = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_addr;
                mem_req.wdata = in_value;
                count_nxt     = count_r + 1'b1;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_addr - 1'b1;
                idx_nxt       = cnt_addr;
                state_nxt     = ple_pkg::S_SHIFT_UP;
              end
            end
            ple_pkg::OP_REMOVE: begin
              if (in_position >= count_r) begin
                done = 1'b1;
                st   = ple_pkg::ST_RANGE;
              end else if (in_position == count_r - 1'b1) begin
                done      = 1'b1;
                count_nxt = count_r - 1'b1;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_addr + 1'b1;
                idx_nxt       = in_addr;
                state_nxt     = ple_pkg::S_SHIFT_DN;
              end
            end
            ple_pkg::OP_READ: begin
              if (in_position >= count_r) begin
                done = 1'b1;
                st   = ple_pkg::ST_RANGE;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_addr;
                state_nxt     = ple_pkg::S_RD_WAIT;
              end
            end
            ple_pkg::OP_CLEAR: begin
              done      = 1'b1;
              count_nxt = '0;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ple_pkg::S_RD_WAIT: begin
        done      = 1'b1;
        rd        = mem_rdata;
        state_nxt = ple_pkg::S_IDLE;
      end

      // Each cycle writes the word read in the previous cycle one place higher
      // and fetches the next lower word.
      ple_pkg::S_SHIFT_UP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = mem_rdata;
        if (idx_r == pos_r + 1'b1) begin
          state_nxt = ple_pkg::S_INS_WRITE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r - ple_pkg::ADDR_W'(2);
          idx_nxt       = idx_r - 1'b1;
        end
      end

      ple_pkg::S_INS_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = val_r;
        count_nxt     = count_r + 1'b1;
        done          = 1'b1;
        state_nxt     = ple_pkg::S_IDLE;
      end

      ple_pkg::S_SHIFT_DN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = mem_rdata;
        if (ple_pkg::CNT_W'(idx_r) + ple_pkg::CNT_W'(2) == count_r) begin
          count_nxt = count_r - 1'b1;
          done      = 1'b1;
          state_nxt = ple_pkg::S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r + ple_pkg::ADDR_W'(2);
          idx_nxt       = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ple_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt      = done;
    out_read_value_nxt = rd;
    out_count_nxt      = count_nxt;
    out_is_empty_nxt   = (count_nxt == '0);
    out_status_nxt     = st;
  end

  assign busy           = (state_r != ple_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ple_pkg::CAP_CNT)
    else $error("element count exceeds capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ple_pkg::ST_FULL |-> out_count == ple_pkg::CAP_CNT)
    else $error("full status reported on a list that is not full");

  a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ple_pkg::S_SHIFT_UP |-> count_r < ple_pkg::CAP_CNT)
    else $error("insert shift running on a full list");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a request is still in progress");

endmodule
